// ===== hdl/atid_pkg.sv =====
`timescale 1ns / 1ps
// atid_pkg: shared widths, operation codes and status codes for the
// packed table block; no dependencies

package atid_pkg;

   localparam int DEPTH_DEF = 128;

   localparam int OP_W     = 2;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 7;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 7;
   localparam int COUNT_W  = 8;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
   localparam logic [OP_W-1:0] OP_READ   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

// ===== hdl/array_table_insert_delete_find.sv =====
`timescale 1ns / 1ps
// packed table of signed words: find, positional delete, insert and read
// find scans from entry 0 up to the count; delete moves the entries above position down one place;
// insert moves entries from position up one place, then writes the value; rejected requests go to the response
// a new request is taken only when idle, after the last result is loaded; the memory walks one entry a cycle
// reset clears the count and all control; table contents are undefined until written
// depends on atid_pkg

module array_table_insert_delete_find #(
   parameter int DEPTH = atid_pkg::DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // value [31:0], position [38:32], zero fill
   input  logic [atid_pkg::REQ_DATA_W-1:0]   req_tdata,
   // op
   input  logic [atid_pkg::OP_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // found_index [6:0], read_value [38:7], entry_count [46:39], zero fill
   output logic [atid_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic [atid_pkg::STATUS_W-1:0]     rsp_tuser
);
   import atid_pkg::*;

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_FIND = 3'd1;
   localparam logic [2:0] S_DEL  = 3'd2;
   localparam logic [2:0] S_INS  = 3'd3;
   localparam logic [2:0] S_RD   = 3'd4;
   localparam logic [2:0] S_RDW  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [CW-1:0]       cmp_idx_ff, cmp_idx_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [FOUND_W-1:0]  res_found_ff, res_found_in;
   logic [VALUE_W-1:0]  res_read_ff, res_read_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [FOUND_W-1:0]  rsp_found_ff;
   logic [VALUE_W-1:0]  rsp_read_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic                out_free;
   logic                load_out;
   logic [OP_W-1:0]     req_op;
   logic [VALUE_W-1:0]  req_value;
   logic [POS_W-1:0]    req_pos;
   logic [CMPW-1:0]     pos_w;
   logic [CMPW-1:0]     cnt_w;

   assign req_op    = req_tuser;
   assign req_value = req_tdata[VALUE_W-1:0];
   assign req_pos   = req_tdata[VALUE_W+POS_W-1:VALUE_W];
   assign pos_w     = CMPW'(req_pos);
   assign cnt_w     = CMPW'(count_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // table memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_read_in   = res_read_ff;
      rd_addr       = idx_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = cmp_idx_ff[AW-1:0];
      wr_data       = rd_data_ff;
      load_out      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               val_in        = req_value;
               pos_in        = AW'(req_pos);
               res_status_in = ST_OK;
               res_found_in  = '0;
               res_read_in   = '0;
               unique case (req_op)
                  OP_FIND: begin
                     idx_in   = '0;
                     state_in = S_FIND;
                  end
                  OP_DELETE: begin
                     if (pos_w >= cnt_w) begin
                        res_status_in = ST_RANGE;
                        state_in      = S_DONE;
                     end else begin
                        idx_in   = CW'(req_pos) + CW'(1);
                        state_in = S_DEL;
                     end
                  end
                  OP_INSERT: begin
                     if (pos_w > cnt_w) begin
                        res_status_in = ST_RANGE;
                        state_in      = S_DONE;
                     end else if (count_ff == CW'(DEPTH)) begin
                        res_status_in = ST_FULL;
                        state_in      = S_DONE;
                     end else begin
                        idx_in   = count_ff;
                        state_in = S_INS;
                     end
                  end
                  OP_READ: begin
                     if (pos_w >= cnt_w) begin
                        res_status_in = ST_RANGE;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FIND: begin
            if (cmp_vld_ff && (rd_data_ff == val_ff)) begin
               res_status_in = ST_OK;
               res_found_in  = FOUND_W'(cmp_idx_ff);
               state_in      = S_DONE;
            end else if (idx_ff < count_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = idx_ff;
               idx_in     = idx_ff + CW'(1);
            end else begin
               res_status_in = ST_NOTFOUND;
               state_in      = S_DONE;
            end
         end
         S_DEL: begin
            // entry read last cycle moves down one place
            if (cmp_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(cmp_idx_ff - CW'(1));
            end
            if (idx_ff < count_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = idx_ff;
               idx_in     = idx_ff + CW'(1);
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end
         end
         S_INS: begin
            // entry read last cycle moves up one place
            if (cmp_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = cmp_idx_ff[AW-1:0];
            end
            if (idx_ff > CW'(pos_ff)) begin
               rd_addr    = AW'(idx_ff - CW'(1));
               cmp_vld_in = 1'b1;
               cmp_idx_in = idx_ff;
               idx_in     = idx_ff - CW'(1);
            end else if (!cmp_vld_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff;
               wr_data  = val_ff;
               count_in = count_ff + CW'(1);
               state_in = S_DONE;
            end
         end
         S_RD: begin
            rd_addr  = pos_ff;
            state_in = S_RDW;
         end
         S_RDW: begin
            res_read_in = rd_data_ff;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_read_ff   <= res_read_in;
      if (load_out) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_read_ff   <= res_read_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_read_ff, rsp_found_ff};

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds table depth");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ($past(state_ff) == S_DEL || $past(state_ff) == S_INS))
      else $error("entry count changed outside a shift walk");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !cmp_vld_ff)
      else $error("memory read pending while idle");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwrote an untaken transaction");
`endif

endmodule
